// ===== rtl/kscu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyword substitution cipher unit.
// Used by the channel interfaces, the table builder and the top level.
package kscu_pkg;

    // Alphabet and keyword geometry
    localparam int ALPHA       = 26;
    localparam int LETTER_W    = 5;
    localparam int KEY_SLOTS   = 10;
    localparam int KEYWORD_MAX = 10;
    localparam int KEY_BOUND_I = (KEYWORD_MAX < KEY_SLOTS) ? KEYWORD_MAX : KEY_SLOTS;
    localparam int LEN_W       = 4;
    localparam int KEY_W       = KEY_SLOTS * LETTER_W;

    // Channel payload widths
    localparam int SYM_IN_W  = 8;
    localparam int SYM_OUT_W = 7;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic REG_LETTERS = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    // Opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // ASCII bounds of the uppercase letters
    localparam logic [SYM_IN_W-1:0] ASCII_A = 8'd65;
    localparam logic [SYM_IN_W-1:0] ASCII_Z = 8'd90;

    localparam logic [LEN_W-1:0]    LEN_RESET = 4'd10;
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA - 1);

    typedef logic [LETTER_W-1:0] t_letter;

    // One table write from the builder: cipher[pos] = letter, inverse[letter] = pos.
    typedef struct packed {
        logic    en;
        t_letter pos;
        t_letter letter;
    } t_tbl_wr;

endpackage

// ===== rtl/kscu_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the cipher unit: valid/ready with opcode and symbol.
// Depends on kscu_pkg for the payload widths.
interface kscu_in_if;
    import kscu_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SYM_IN_W-1:0] symbol_in;

    modport source (output valid, output opcode, output symbol_in, input ready);
    modport sink   (input valid, input opcode, input symbol_in, output ready);
endinterface

// ===== rtl/kscu_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the cipher unit: valid/ready with the mapped letter.
// Depends on kscu_pkg for the payload width.
interface kscu_out_if;
    import kscu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SYM_OUT_W-1:0] symbol_out;

    modport source (output valid, output symbol_out, input ready);
    modport sink   (input valid, input symbol_out, output ready);
endinterface

// ===== rtl/kscu_builder.sv =====
`timescale 1ns / 1ps
// Sequencer that rebuilds the cipher alphabet, checking one candidate letter per cycle.
// Depends on kscu_pkg; drives table writes into the top level.
module kscu_builder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [kscu_pkg::KEY_W-1:0] i_key,
    input  logic [kscu_pkg::LEN_W-1:0] i_len,
    output kscu_pkg::t_tbl_wr       o_wr,
    output logic                    o_busy
);
    import kscu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_FILL
    } t_state;

    localparam logic [LEN_W-1:0] KEY_BOUND = LEN_W'(KEY_BOUND_I);

    t_state           r_state;
    t_letter          r_idx;
    t_letter          r_pos;
    logic [ALPHA-1:0] r_used;

    t_letter          w_key [KEY_SLOTS];
    logic [LEN_W-1:0] w_len;
    t_letter          w_cand;
    logic             w_take;

    // Split the keyword register into letter slots.
    always_comb begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
            w_key[k] = i_key[k*LETTER_W +: LETTER_W];
        end
    end

    // Saturate the length to the number of usable slots.
    assign w_len = (i_len > KEY_BOUND) ? KEY_BOUND : i_len;

    // Candidate letter of this step and whether it gets placed.
    always_comb begin
        w_cand = r_idx;
        w_take = 1'b0;
        case (r_state)
            S_KEY: begin
                w_cand = w_key[r_idx[LEN_W-1:0]];
                w_take = (r_idx[LEN_W-1:0] < w_len) && (w_cand <= LAST_LETTER)
                         && !r_used[w_cand];
            end
            S_FILL: begin
                w_take = !r_used[r_idx];
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
    end

    assign o_wr.en     = w_take;
    assign o_wr.pos    = r_pos;
    assign o_wr.letter = w_cand;
    assign o_busy      = (r_state != S_IDLE);

    // State, step counter, fill position and used-letter mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_state <= S_KEY;
            r_idx   <= '0;
            r_pos   <= '0;
            r_used  <= '0;
        end else begin
            if (w_take) begin
                r_used[w_cand] <= 1'b1;
                r_pos          <= r_pos + 1'b1;
            end
            case (r_state)
                S_KEY: begin
                    if (r_idx[LEN_W-1:0] >= w_len) begin
                        r_state <= S_FILL;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FILL: begin
                    if (r_idx == LAST_LETTER) begin
                        r_state <= S_IDLE;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/keyword_substitution_cipher_unit.sv =====
`timescale 1ns / 1ps
// Top level of the keyword substitution cipher unit: APB registers,
// table storage and the three-stage lookup pipeline. Uses kscu_pkg,
// kscu_in_if, kscu_out_if and kscu_builder.
//
//  Channel   Direction  Payload                     Transfer when
//  i_in      in         opcode, symbol_in[7:0]      valid && ready
//  o_out     out        symbol_out[6:0]             valid && ready
//  APB       in/out     paddr[3:0], pwdata[63:0]    psel && penable && pwrite
//
// One item enters per cycle while the builder is idle and o_out is not stalled; each result passes
// through stage 1, stage 2 and the output register. Bytes that are not uppercase letters are taken
// and dropped in the first stage. After reset and after each register write the builder walks up
// to ten keyword slots and then all 26 letters, and i_in.ready stays low while it runs.
// A stall on o_out holds each stage whose item cannot move on; nothing is lost or repeated.
module keyword_substitution_cipher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kscu_in_if.sink                         i_in,
    kscu_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kscu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kscu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kscu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import kscu_pkg::*;

    // Configuration registers
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic             w_cfg_wr;
    logic             w_reg_idx;

    // Alphabet tables
    t_letter r_cipher  [ALPHA];
    t_letter r_inverse [ALPHA];
    t_tbl_wr w_wr;
    logic    w_busy;

    // Pipeline stages
    logic     r_v1, r_v2, r_v3;
    logic     r_op1;
    t_letter  r_x1;
    t_letter  r_l2;
    logic [SYM_OUT_W-1:0] r_sym3;
    logic     w_en1, w_en2, w_en3;
    logic     w_accept;
    logic     w_is_letter;
    logic [SYM_IN_W-1:0] w_diff;

    // APB register access; the index is the 8-byte slot.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[CFG_ADDR_W-1];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_len <= LEN_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_LETTERS: r_key <= pwdata[KEY_W-1:0];
                REG_LENGTH:  r_len <= pwdata[LEN_W-1:0];
                default:     r_len <= r_len;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_LETTERS: prdata = CFG_DATA_W'(r_key);
            REG_LENGTH:  prdata = CFG_DATA_W'(r_len);
            default:     prdata = '0;
        endcase
    end

    // Table builder, restarted by every register write.
    kscu_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_wr),
        .i_key   (r_key),
        .i_len   (r_len),
        .o_wr    (w_wr),
        .o_busy  (w_busy)
    );

    // Table storage: each builder write sets a pair of inverse entries.
    always_ff @(posedge i_clk) begin
        if (w_wr.en) begin
            r_cipher[w_wr.pos]     <= w_wr.letter;
            r_inverse[w_wr.letter] <= w_wr.pos;
        end
    end

    // Stage enables ripple back from the output register.
    assign w_en3    = !r_v3 || o_out.ready;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign i_in.ready = !w_busy && w_en1;
    assign w_accept = i_in.valid && i_in.ready;

    assign w_is_letter = (i_in.symbol_in >= ASCII_A) && (i_in.symbol_in <= ASCII_Z);
    assign w_diff      = i_in.symbol_in - ASCII_A;

    // Stage 1: letter check and table index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_accept && w_is_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_op1 <= i_in.opcode;
            r_x1  <= w_diff[LETTER_W-1:0];
        end
    end

    // Stage 2: table lookup chosen by the opcode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            case (r_op1)
                OP_ENCRYPT: r_l2 <= r_cipher[r_x1];
                OP_DECRYPT: r_l2 <= r_inverse[r_x1];
                default:    r_l2 <= r_cipher[r_x1];
            endcase
        end
    end

    // Stage 3: back to ASCII in the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_sym3 <= ASCII_A[SYM_OUT_W-1:0] + SYM_OUT_W'(r_l2);
        end
    end

    assign o_out.valid      = r_v3;
    assign o_out.symbol_out = r_sym3;

endmodule
